[rtl/sha1s_pkg.sv]
// ----------------------------------------------------------------------------
// sha1s_pkg
// shared types, constants and helper functions of the sha-1 stream hasher
// ----------------------------------------------------------------------------
package sha1s_pkg;

    typedef logic [31:0]      t_word;
    typedef logic [4:0][31:0] t_vars;

    localparam int NumVars    = 5;
    localparam int SchedDepth = 16;

    localparam t_vars SHA1_IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam t_word K_ROUND0 = 32'h5A827999;
    localparam t_word K_ROUND1 = 32'h6ED9EBA1;
    localparam t_word K_ROUND2 = 32'h8F1BBCDC;
    localparam t_word K_ROUND3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] BLOCK_END  = 6'd63;
    localparam logic [2:0] LAST_OIDX  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_rnd_ctrl;

    function automatic t_word rotl1(input t_word x);
        return {x[30:0], x[31]};
    endfunction

    function automatic t_word rotl5(input t_word x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic t_word rotl30(input t_word x);
        return {x[1:0], x[31:2]};
    endfunction

endpackage

[rtl/sha1s_ifs.sv]
// ----------------------------------------------------------------------------
// sha1s channel interfaces
// valid/ready channels for message beats and digest beats
// ----------------------------------------------------------------------------
interface sha1s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       no_data;
    logic       last;

    modport source (output valid, output data_byte, output no_data, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input no_data, input last,
                    output ready);
endinterface

interface sha1s_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        last_word;

    modport source (output valid, output digest_word, output last_word, input ready);
    modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

[rtl/sha1s_wcell.sv]
// ----------------------------------------------------------------------------
// sha1s_wcell
// one 32-bit cell of the message schedule line, loads from its neighbor
// ----------------------------------------------------------------------------
module sha1s_wcell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  sha1s_pkg::t_word i_word,
    output sha1s_pkg::t_word o_word
);
    import sha1s_pkg::*;

    t_word r_word;
    t_word n_word;

    always_comb begin
        n_word = i_shift ? i_word : r_word;
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

[rtl/sha1s_round.sv]
// ----------------------------------------------------------------------------
// sha1s_round
// working variables a..e and round counter, one sha-1 round per step
// ----------------------------------------------------------------------------
module sha1s_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha1s_pkg::t_rnd_ctrl i_ctrl,
    input  sha1s_pkg::t_vars     i_init,
    input  sha1s_pkg::t_word     i_wt,
    output sha1s_pkg::t_vars     o_vars,
    output logic                 o_done
);
    import sha1s_pkg::*;

    t_vars      r_v;
    t_vars      n_v;
    logic [6:0] r_cnt;
    logic [6:0] n_cnt;
    t_word      f;
    t_word      k;
    t_word      tmp;

    always_comb begin
        if (r_cnt < 7'd20) begin
            f = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            k = K_ROUND0;
        end else if (r_cnt < 7'd40) begin
            f = r_v[1] ^ r_v[2] ^ r_v[3];
            k = K_ROUND1;
        end else if (r_cnt < 7'd60) begin
            f = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            k = K_ROUND2;
        end else begin
            f = r_v[1] ^ r_v[2] ^ r_v[3];
            k = K_ROUND3;
        end
        tmp = rotl5(r_v[0]) + f + r_v[4] + k + i_wt;
    end

    always_comb begin
        n_v   = r_v;
        n_cnt = r_cnt;
        if (i_ctrl.load) begin
            n_v   = i_init;
            n_cnt = '0;
        end else if (i_ctrl.step) begin
            n_v[4] = r_v[3];
            n_v[3] = r_v[2];
            n_v[2] = rotl30(r_v[1]);
            n_v[1] = r_v[0];
            n_v[0] = tmp;
            n_cnt  = (r_cnt == LAST_ROUND) ? '0 : r_cnt + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_cnt <= '0;
        end else begin
            r_v   <= n_v;
            r_cnt <= n_cnt;
        end
    end

    assign o_vars = r_v;
    assign o_done = i_ctrl.step && (r_cnt == LAST_ROUND);

endmodule

[rtl/sha1_stream_hasher_unit.sv]
// ----------------------------------------------------------------------------
// sha1_stream_hasher_unit
// streaming sha-1: byte beats in, five digest word beats out per message
// ----------------------------------------------------------------------------
// One message byte is taken per beat (none when no_data is set); every 64th
// byte starts a compression that runs 80 rounds, one per cycle, on a line of
// 16 schedule cells and then folds into the chain value. A beat with last
// set then pads the message one byte per cycle (over one or two blocks, each
// block followed by its compression) and presents h0..h4 as five output beats.
// No input beat is taken from the last beat until the fifth digest word is
// taken.
module sha1_stream_hasher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha1s_in_if.sink    i_in,
    sha1s_out_if.source o_out
);
    import sha1s_pkg::*;

    t_state      r_state;
    t_state      n_state;
    logic [5:0]  r_pos;
    logic [63:0] r_byte_count;
    logic [23:0] r_acc;
    t_vars       r_chain;
    logic        r_padding;
    logic        r_pad_first;
    logic        r_len_phase;
    logic        r_pad_done;
    logic [2:0]  r_oidx;

    logic        in_fire;
    logic        out_fire;
    logic        put_en;
    logic [7:0]  put_byte;
    logic [63:0] len_bits;
    logic [7:0]  len_byte;
    logic        push;
    logic        blk_full;
    logic        shift_en;
    t_word       w_new;
    t_word       feed;
    t_word       w_q [SchedDepth];
    t_rnd_ctrl   rnd_ctrl;
    t_vars       rnd_vars;
    logic        rnd_done;

    // schedule line: bytes pack into words, rounds extend in place
    for (genvar g = 0; g < SchedDepth; g++) begin : g_sched
        if (g == SchedDepth - 1) begin : g_tail
            sha1s_wcell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift_en),
                .i_word  (feed),
                .o_word  (w_q[g])
            );
        end else begin : g_body
            sha1s_wcell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift_en),
                .i_word  (w_q[g+1]),
                .o_word  (w_q[g])
            );
        end
    end

    sha1s_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (rnd_ctrl),
        .i_init  (r_chain),
        .i_wt    (w_q[0]),
        .o_vars  (rnd_vars),
        .o_done  (rnd_done)
    );

    // datapath selects
    always_comb begin
        in_fire  = i_in.valid && i_in.ready;
        out_fire = o_out.valid && o_out.ready;
        len_bits = {r_byte_count[60:0], 3'b000};
        len_byte = len_bits[{~r_pos[2:0], 3'b000} +: 8];
        put_en   = 1'b0;
        put_byte = i_in.data_byte;
        if (r_state == ST_IDLE) begin
            put_en = in_fire && !i_in.no_data;
        end else if (r_state == ST_PAD) begin
            put_en   = 1'b1;
            put_byte = r_pad_first ? PAD_BYTE : (r_len_phase ? len_byte : ZERO_BYTE);
        end
        push     = put_en && (r_pos[1:0] == 2'b11);
        blk_full = put_en && (r_pos == BLOCK_END);
        shift_en = push || (r_state == ST_ROUND);
        w_new    = rotl1(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);
        feed     = (r_state == ST_ROUND) ? w_new : {r_acc, put_byte};
        rnd_ctrl.load = blk_full;
        rnd_ctrl.step = (r_state == ST_ROUND);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (blk_full) begin
                        n_state = ST_ROUND;
                    end else if (i_in.last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (blk_full) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (rnd_done) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (r_pad_done) begin
                    n_state = ST_OUT;
                end else if (r_padding) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_fire && (r_oidx == LAST_OIDX)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // channel outputs
    always_comb begin
        i_in.ready        = (r_state == ST_IDLE);
        o_out.valid       = (r_state == ST_OUT);
        o_out.digest_word = r_chain[r_oidx];
        o_out.last_word   = (r_oidx == LAST_OIDX);
    end

    always_ff @(posedge i_clk) begin
        if (put_en) begin
            r_acc <= {r_acc[15:0], put_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pos        <= '0;
            r_byte_count <= '0;
            r_chain      <= SHA1_IV;
            r_padding    <= 1'b0;
            r_pad_first  <= 1'b0;
            r_len_phase  <= 1'b0;
            r_pad_done   <= 1'b0;
            r_oidx       <= '0;
        end else begin
            r_state <= n_state;
            if (put_en) begin
                r_pos <= r_pos + 6'd1;
            end
            if (r_state == ST_IDLE && in_fire) begin
                if (!i_in.no_data) begin
                    r_byte_count <= r_byte_count + 64'd1;
                end
                if (i_in.last) begin
                    r_padding   <= 1'b1;
                    r_pad_first <= 1'b1;
                    r_len_phase <= 1'b0;
                end
            end
            if (r_state == ST_PAD) begin
                r_pad_first <= 1'b0;
                // length field starts once the fill reaches byte 56
                if (!r_len_phase && (r_pos + 6'd1 == LEN_POS)) begin
                    r_len_phase <= 1'b1;
                end
                if (r_len_phase && (r_pos == BLOCK_END)) begin
                    r_pad_done <= 1'b1;
                end
            end
            if (r_state == ST_ADD) begin
                for (int i = 0; i < NumVars; i++) begin
                    r_chain[i] <= r_chain[i] + rnd_vars[i];
                end
            end
            if (out_fire) begin
                if (r_oidx == LAST_OIDX) begin
                    r_oidx       <= '0;
                    r_chain      <= SHA1_IV;
                    r_byte_count <= '0;
                    r_pos        <= '0;
                    r_padding    <= 1'b0;
                    r_pad_first  <= 1'b0;
                    r_len_phase  <= 1'b0;
                    r_pad_done   <= 1'b0;
                end else begin
                    r_oidx <= r_oidx + 3'd1;
                end
            end
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input and output open together");

    a_round_to_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && rnd_done) |=> (r_state == ST_ADD))
        else $error("compression did not end in fold");

    a_pos_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_pos == r_byte_count[5:0]))
        else $error("block position out of step with byte count");

    a_digest_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_out.last_word) |=> (r_byte_count == '0 && r_pos == '0
            && r_state == ST_IDLE))
        else $error("message state not cleared after digest");

    a_out_only_after_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> r_pad_done)
        else $error("digest beat without padded final block");

endmodule
